[sv/psi_section_parser_core_assert.svh]
// Assertion macros for the PSI section parser.
// Modules that include this must have clk and arst_n in scope.
`ifndef PSI_SECTION_PARSER_CORE_ASSERT_SVH
`define PSI_SECTION_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PSP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define PSP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[sv/psp_pkg.sv]
// Shared types and constants of the PSI section parser.
// No dependencies.
package psp_pkg;

	localparam int MAX_PROGRAMS = 8;
	localparam int MAX_STREAMS  = 15;
	localparam int PROG_IDX_W   = $clog2(MAX_PROGRAMS);
	localparam int FIFO_DEPTH   = 4;
	localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
	localparam int ES_W         = 17;

	localparam logic [12:0] POS_MAX    = 13'h1FFF;
	localparam logic [11:0] PAT_HDR    = 12'd9;
	localparam logic [7:0]  TID_PAT    = 8'h00;
	localparam logic [7:0]  TID_PMT    = 8'h02;
	localparam logic [7:0]  TYPE_VIDEO = 8'h02;
	localparam logic [7:0]  TYPE_AUDIO = 8'h03;
	localparam logic [7:0]  TYPE_PRIV  = 8'h06;
	localparam logic [7:0]  TAG_TTX    = 8'd86;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_PAT  = 2'd1,
		MODE_PMT  = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		KIND_PAT_ENTRY = 3'd0,
		KIND_PAT_SUM   = 3'd1,
		KIND_PMT_ES    = 3'd2,
		KIND_PMT_SUM   = 3'd3,
		KIND_PMT_UNM   = 3'd4
	} kind_t;

	// classified byte as queued between front and back
	typedef struct packed {
		logic [7:0] data;
		logic       start;
		logic       is_pat;
		logic       is_pmt;
	} fe_item_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [3:0]  entry_index;
		logic [2:0]  channel_index;
		logic [15:0] number_value;
		logic [12:0] pid_value;
		logic [12:0] audio_pid;
		logic [7:0]  stream_type;
		logic [11:0] length_value;
		logic [7:0]  descriptor_tag;
		logic [4:0]  version;
		logic [3:0]  entry_count;
		logic        has_teletext;
	} result_t;

	// queue status seen by the front and back
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

[sv/psp_if.sv]
// Channel interfaces of the PSI section parser: byte input and result output.
// No dependencies.
interface psp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       section_start;
	modport source (output valid, output data_byte, output section_start, input ready);
	modport sink (input valid, input data_byte, input section_start, output ready);
endinterface

interface psp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  result_kind;
	logic [3:0]  entry_index;
	logic [2:0]  channel_index;
	logic [15:0] number_value;
	logic [12:0] pid_value;
	logic [12:0] audio_pid;
	logic [7:0]  stream_type;
	logic [11:0] length_value;
	logic [7:0]  descriptor_tag;
	logic [4:0]  version;
	logic [3:0]  entry_count;
	logic        has_teletext;
	modport source (output valid, output result_kind, output entry_index,
		output channel_index, output number_value, output pid_value, output audio_pid,
		output stream_type, output length_value, output descriptor_tag, output version,
		output entry_count, output has_teletext, input ready);
	modport sink (input valid, input result_kind, input entry_index,
		input channel_index, input number_value, input pid_value, input audio_pid,
		input stream_type, input length_value, input descriptor_tag, input version,
		input entry_count, input has_teletext, output ready);
endinterface

[sv/psp_fifo.sv]
// Short queue of classified bytes between front and back.
// Depends on psp_pkg and psi_section_parser_core_assert.svh.
`include "psi_section_parser_core_assert.svh"
module psp_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  psp_pkg::fe_item_t   wr_item,
	input  logic                pop,
	output psp_pkg::fe_item_t   rd_item,
	output psp_pkg::fifo_stat_t stat
);
	psp_pkg::fe_item_t                mem_q [psp_pkg::FIFO_DEPTH];
	logic [psp_pkg::FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [psp_pkg::FIFO_PTR_W-1:0]   rd_ptr_q;
	logic [psp_pkg::FIFO_PTR_W:0]     count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	assign rd_item    = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == (psp_pkg::FIFO_PTR_W+1)'(psp_pkg::FIFO_DEPTH));
	assign stat.empty = (count_q == '0);

	`PSP_ASSERT_NOW(a_no_overflow, push, !stat.full || pop)
	`PSP_ASSERT_NOW(a_no_underflow, pop, !stat.empty)
	`PSP_ASSERT_NOW(a_count_range, 1'b1,
		count_q <= (psp_pkg::FIFO_PTR_W+1)'(psp_pkg::FIFO_DEPTH))
endmodule

[sv/psp_front.sv]
// Front end: takes bytes off the input channel and classifies table ids.
// Depends on psp_pkg and psp_if.
module psp_front (
	psp_in_if.sink              in_ch,
	input  psp_pkg::fifo_stat_t stat,
	output logic                push,
	output psp_pkg::fe_item_t   item
);
	assign in_ch.ready = !stat.full;
	assign push        = in_ch.valid && !stat.full;

	always_comb begin
		item.data   = in_ch.data_byte;
		item.start  = in_ch.section_start;
		item.is_pat = in_ch.section_start && (in_ch.data_byte == psp_pkg::TID_PAT);
		item.is_pmt = in_ch.section_start && (in_ch.data_byte == psp_pkg::TID_PMT);
	end
endmodule

[sv/psp_parser.sv]
// Back end: PAT/PMT byte parser with program table and result register.
// Depends on psp_pkg and psi_section_parser_core_assert.svh.
`include "psi_section_parser_core_assert.svh"
module psp_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  psp_pkg::fifo_stat_t stat,
	input  psp_pkg::fe_item_t   item,
	output logic                pop,
	input  logic                res_ready,
	output logic                res_valid,
	output psp_pkg::result_t    res
);
	logic [12:0]             pos_q;
	psp_pkg::mode_t          mode_q;
	logic [11:0]             sec_len_q;
	logic [15:0]             prog_q [psp_pkg::MAX_PROGRAMS];
	logic [3:0]              prog_total_q;
	logic [15:0]             id_q;
	logic [4:0]              ver_q;
	logic [11:0]             info_len_q;
	logic [psp_pkg::ES_W-1:0] es_q;
	logic [15:0]             pend_prog_q;
	logic [7:0]              pend_type_q;
	logic [12:0]             pend_pid_q;
	logic [11:0]             pend_info_q;
	logic [3:0]              streams_q;
	logic [12:0]             audio_q;
	logic [12:0]             video_q;
	logic                    ttx_q;
	logic [2:0]              slot_q;
	logic                    out_valid_q;
	psp_pkg::result_t        out_q;

	logic [12:0]             n_pos;
	psp_pkg::mode_t          n_mode;
	logic [11:0]             n_sec_len;
	logic [3:0]              n_prog_total;
	logic [15:0]             n_id;
	logic [4:0]              n_ver;
	logic [11:0]             n_info_len;
	logic [psp_pkg::ES_W-1:0] n_es;
	logic [15:0]             n_pend_prog;
	logic [7:0]              n_pend_type;
	logic [12:0]             n_pend_pid;
	logic [11:0]             n_pend_info;
	logic [3:0]              n_streams;
	logic [12:0]             n_audio;
	logic [12:0]             n_video;
	logic                    n_ttx;
	logic [2:0]              n_slot;
	logic                    tbl_we;
	logic [psp_pkg::PROG_IDX_W-1:0] tbl_idx;
	logic                    r_v;
	psp_pkg::result_t        r;

	logic                    act;
	psp_pkg::mode_t          eff_mode;
	logic [12:0]             pos;
	logic [11:0]             sec_full;
	logic [11:0]             cnt;
	logic [12:0]             rel;
	logic [10:0]             idx;
	logic [15:0]             id_full;
	logic                    hit;
	logic [psp_pkg::ES_W-1:0] diff;
	logic [11:0]             info_full;
	logic [12:0]             pid_full;
	logic                    es_done;
	logic [7:0]              es_tag;
	logic [psp_pkg::ES_W:0]  es_end;

	assign pop = !stat.empty && (!out_valid_q || res_ready);

	always_comb begin
		n_pos = pos_q; n_mode = mode_q; n_sec_len = sec_len_q;
		n_prog_total = prog_total_q; n_id = id_q; n_ver = ver_q;
		n_info_len = info_len_q; n_es = es_q; n_pend_prog = pend_prog_q;
		n_pend_type = pend_type_q; n_pend_pid = pend_pid_q; n_pend_info = pend_info_q;
		n_streams = streams_q; n_audio = audio_q; n_video = video_q;
		n_ttx = ttx_q; n_slot = slot_q;
		tbl_we = 1'b0; tbl_idx = '0;
		r_v = 1'b0; r = '0;
		es_done = 1'b0; es_tag = '0;
		hit = 1'b0;
		pos = pos_q; eff_mode = mode_q;
		sec_full  = {sec_len_q[11:8], item.data};
		id_full   = {id_q[15:8], item.data};
		info_full = {pend_info_q[11:8], item.data};
		pid_full  = {pend_pid_q[12:8], item.data};
		cnt = '0; rel = '0; idx = '0; diff = '0; es_end = '0;

		if (item.start) begin
			pos = '0;
			if (item.is_pat) eff_mode = psp_pkg::MODE_PAT;
			else if (item.is_pmt) eff_mode = psp_pkg::MODE_PMT;
			else eff_mode = psp_pkg::MODE_IDLE;
			if (item.is_pmt) begin
				n_streams = '0; n_audio = '0; n_video = '0; n_ttx = 1'b0; n_slot = '0;
			end
		end
		act = (eff_mode != psp_pkg::MODE_IDLE);
		n_mode = eff_mode;

		if (act && eff_mode == psp_pkg::MODE_PAT) begin
			if (pos == 13'd1) begin
				n_sec_len = {item.data[3:0], 8'h00};
			end else if (pos == 13'd2) begin
				n_sec_len = sec_full;
				cnt = (sec_full >= psp_pkg::PAT_HDR) ? ((sec_full - psp_pkg::PAT_HDR) >> 2) : '0;
				n_prog_total = (cnt > 12'(psp_pkg::MAX_PROGRAMS)) ?
					4'(psp_pkg::MAX_PROGRAMS) : cnt[3:0];
			end else if (pos == 13'd3) begin
				n_id = {item.data, 8'h00};
			end else if (pos == 13'd4) begin
				n_id = id_full;
			end else if (pos == 13'd5) begin
				n_ver = item.data[5:1];
			end else if (pos >= 13'd8) begin
				rel = pos - 13'd8;
				idx = rel[12:2];
				if (idx >= {7'd0, prog_total_q}) begin
					if (rel == {7'd0, prog_total_q, 2'b00}) begin
						r_v = 1'b1;
						r.result_kind  = psp_pkg::KIND_PAT_SUM;
						r.number_value = id_q;
						r.length_value = sec_len_q;
						r.version      = ver_q;
						r.entry_count  = prog_total_q;
						n_mode = psp_pkg::MODE_IDLE;
					end
				end else begin
					case (rel[1:0])
						2'd0: n_pend_prog = {item.data, 8'h00};
						2'd1: n_pend_prog = {pend_prog_q[15:8], item.data};
						2'd2: n_pend_pid = {item.data[4:0], 8'h00};
						default: begin
							n_pend_pid = pid_full;
							tbl_we  = 1'b1;
							tbl_idx = idx[psp_pkg::PROG_IDX_W-1:0];
							r_v = 1'b1;
							r.result_kind  = psp_pkg::KIND_PAT_ENTRY;
							r.entry_index  = idx[3:0];
							r.number_value = pend_prog_q;
							r.pid_value    = pid_full;
						end
					endcase
				end
			end
		end else if (act) begin
			if (pos == 13'd1) begin
				n_sec_len = {item.data[3:0], 8'h00};
			end else if (pos == 13'd2) begin
				n_sec_len = sec_full;
			end else if (pos == 13'd3) begin
				n_id = {item.data, 8'h00};
			end else if (pos == 13'd4) begin
				n_id = id_full;
				// lowest matching slot wins
				for (int i = psp_pkg::MAX_PROGRAMS - 1; i >= 0; i--) begin
					if ((5'(i) < {1'b0, prog_total_q}) && (prog_q[i] == id_full)) begin
						hit = 1'b1;
						n_slot = 3'(i);
					end
				end
				if (!hit) begin
					r_v = 1'b1;
					r.result_kind  = psp_pkg::KIND_PMT_UNM;
					r.number_value = id_full;
					r.length_value = sec_len_q;
					n_mode = psp_pkg::MODE_IDLE;
				end
			end else if (pos == 13'd10) begin
				n_info_len = {item.data[3:0], 8'h00};
			end else if (pos == 13'd11) begin
				n_info_len = {info_len_q[11:8], item.data};
				n_es = psp_pkg::ES_W'(12) + psp_pkg::ES_W'({info_len_q[11:8], item.data});
			end else if (pos >= 13'd12 && psp_pkg::ES_W'(pos) >= es_q) begin
				diff = psp_pkg::ES_W'(pos) - es_q;
				es_end = {1'b0, es_q} + (psp_pkg::ES_W+1)'(5);
				case (diff)
					psp_pkg::ES_W'(0): begin
						if (streams_q >= 4'(psp_pkg::MAX_STREAMS) ||
								es_end >= (psp_pkg::ES_W+1)'(sec_len_q)) begin
							r_v = 1'b1;
							r.result_kind   = psp_pkg::KIND_PMT_SUM;
							r.channel_index = slot_q;
							r.number_value  = id_q;
							r.pid_value     = video_q;
							r.audio_pid     = audio_q;
							r.length_value  = sec_len_q;
							r.entry_count   = streams_q;
							r.has_teletext  = ttx_q;
							n_mode = psp_pkg::MODE_IDLE;
						end else begin
							n_pend_type = item.data;
						end
					end
					psp_pkg::ES_W'(1): n_pend_pid = {item.data[4:0], 8'h00};
					psp_pkg::ES_W'(2): n_pend_pid = pid_full;
					psp_pkg::ES_W'(3): n_pend_info = {item.data[3:0], 8'h00};
					psp_pkg::ES_W'(4): begin
						n_pend_info = info_full;
						if (info_full == '0) begin
							n_es = es_q + psp_pkg::ES_W'(5);
							es_done = 1'b1;
						end
					end
					psp_pkg::ES_W'(5): begin
						n_es = es_q + psp_pkg::ES_W'(5) + psp_pkg::ES_W'(pend_info_q);
						es_done = 1'b1;
						es_tag = item.data;
					end
					default: ;
				endcase
				if (es_done) begin
					r_v = 1'b1;
					r.result_kind    = psp_pkg::KIND_PMT_ES;
					r.entry_index    = streams_q;
					r.channel_index  = slot_q;
					r.number_value   = id_q;
					r.pid_value      = pend_pid_q;
					r.stream_type    = pend_type_q;
					r.length_value   = n_pend_info;
					r.descriptor_tag = es_tag;
					if (pend_type_q == psp_pkg::TYPE_AUDIO) n_audio = pend_pid_q;
					else if (pend_type_q == psp_pkg::TYPE_VIDEO) n_video = pend_pid_q;
					if (pend_type_q == psp_pkg::TYPE_PRIV && es_tag == psp_pkg::TAG_TTX)
						n_ttx = 1'b1;
					n_streams = streams_q + 4'd1;
				end
			end
		end

		if (act) n_pos = (pos != psp_pkg::POS_MAX) ? pos + 13'd1 : pos;
	end

	always_ff @(posedge clk) begin
		if (pop && tbl_we) begin
			prog_q[tbl_idx] <= n_pend_prog;
		end
		if (pop && r_v) begin
			out_q <= r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; mode_q <= psp_pkg::MODE_IDLE; sec_len_q <= '0;
			prog_total_q <= '0; id_q <= '0; ver_q <= '0; info_len_q <= '0;
			es_q <= '0; pend_prog_q <= '0; pend_type_q <= '0; pend_pid_q <= '0;
			pend_info_q <= '0; streams_q <= '0; audio_q <= '0; video_q <= '0;
			ttx_q <= 1'b0; slot_q <= '0; out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				pos_q <= n_pos; mode_q <= n_mode; sec_len_q <= n_sec_len;
				prog_total_q <= n_prog_total; id_q <= n_id; ver_q <= n_ver;
				info_len_q <= n_info_len; es_q <= n_es; pend_prog_q <= n_pend_prog;
				pend_type_q <= n_pend_type; pend_pid_q <= n_pend_pid;
				pend_info_q <= n_pend_info; streams_q <= n_streams; audio_q <= n_audio;
				video_q <= n_video; ttx_q <= n_ttx; slot_q <= n_slot;
			end
			if (pop && r_v) out_valid_q <= 1'b1;
			else if (res_ready) out_valid_q <= 1'b0;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

	`PSP_ASSERT_NOW(a_result_needs_mode, pop && r_v, eff_mode != psp_pkg::MODE_IDLE)
	`PSP_ASSERT_NEXT(a_idle_after_summary,
		pop && r_v && (r.result_kind == psp_pkg::KIND_PAT_SUM ||
			r.result_kind == psp_pkg::KIND_PMT_SUM || r.result_kind == psp_pkg::KIND_PMT_UNM),
		mode_q == psp_pkg::MODE_IDLE)
	`PSP_ASSERT_NOW(a_total_range, 1'b1, prog_total_q <= 4'(psp_pkg::MAX_PROGRAMS))
endmodule

[sv/psi_section_parser_core.sv]
// PSI section parser: one section byte per transfer, table id flagged by section_start.
// A PAT gives one result per program (up to 8) and a summary; a PMT whose program is in
// the stored PAT gives one result per stream (up to 15) and a summary, else one unmatched
// result. One byte is taken per cycle while the byte queue has room; the parser handles
// each byte combinationally as it leaves the queue, and a four-entry byte queue plus a
// one-entry result register let input keep flowing while a result waits in that register.
// Depends on psp_pkg, psp_if, psp_front, psp_fifo and psp_parser.
module psi_section_parser_core (
	input logic        clk,
	input logic        arst_n,
	psp_in_if.sink     in_ch,
	psp_out_if.source  out_ch
);
	psp_pkg::fifo_stat_t stat;
	psp_pkg::fe_item_t   wr_item;
	psp_pkg::fe_item_t   rd_item;
	psp_pkg::result_t    res;
	logic                push;
	logic                pop;

	psp_front u_front (
		.in_ch (in_ch),
		.stat  (stat),
		.push  (push),
		.item  (wr_item)
	);

	psp_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.rd_item (rd_item),
		.stat    (stat)
	);

	psp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat      (stat),
		.item      (rd_item),
		.pop       (pop),
		.res_ready (out_ch.ready),
		.res_valid (out_ch.valid),
		.res       (res)
	);

	assign out_ch.result_kind    = res.result_kind;
	assign out_ch.entry_index    = res.entry_index;
	assign out_ch.channel_index  = res.channel_index;
	assign out_ch.number_value   = res.number_value;
	assign out_ch.pid_value      = res.pid_value;
	assign out_ch.audio_pid      = res.audio_pid;
	assign out_ch.stream_type    = res.stream_type;
	assign out_ch.length_value   = res.length_value;
	assign out_ch.descriptor_tag = res.descriptor_tag;
	assign out_ch.version        = res.version;
	assign out_ch.entry_count    = res.entry_count;
	assign out_ch.has_teletext   = res.has_teletext;
endmodule
